FILE: hdl/i2a_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
// No dependencies; used by every module of the block.
`default_nettype none

package i2a_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_CHARS   = 11;
    localparam int CNT_W       = 4;

    // format selector codes
    localparam logic [1:0] CMD_DEC       = 2'd0;
    localparam logic [1:0] CMD_HEX_LO    = 2'd1;
    localparam logic [1:0] CMD_HEX_UP    = 2'd2;
    localparam logic [1:0] CMD_RSVD      = 2'd3;   // unused code, decodes as uppercase hex
    localparam int         CMD_UPPER_BIT = 1;

    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] ASCII_ZERO       = 8'd48;
    localparam logic [7:0] ASCII_MINUS      = 8'd45;
    localparam logic [7:0] LOWER_HEX_OFFSET = 8'd87;
    localparam logic [7:0] UPPER_HEX_OFFSET = 8'd55;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [7:0]       character;
        logic             last_char;
        logic [CNT_W-1:0] total_chars;
    } t_res;

    // classified request handed from front to back
    typedef struct packed {
        logic        hex;
        logic        upper;
        logic        neg;
        logic [31:0] mag;
    } t_job;

endpackage

`default_nettype wire

FILE: hdl/i2a_front.sv
// Front end: accepts requests, classifies format and sign, forms the magnitude,
// and holds classified jobs in a short queue. Depends on i2a_pkg.
`default_nettype none

module i2a_front #(
    parameter int Q_DEPTH = i2a_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire i2a_pkg::t_req i_req,
    output logic               o_job_vld,
    input  wire logic          i_job_pop,
    output i2a_pkg::t_job      o_job
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    i2a_pkg::t_job r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    i2a_pkg::t_job w_job;
    logic          w_wr, w_rd;

    always_comb begin
        w_job.hex   = (i_req.cmd != i2a_pkg::CMD_DEC);
        w_job.upper = i_req.cmd[i2a_pkg::CMD_UPPER_BIT];
        w_job.neg   = (i_req.cmd == i2a_pkg::CMD_DEC) && i_req.value[31];
        // unsigned negate also covers the most negative value
        w_job.mag   = w_job.neg ? (32'd0 - i_req.value) : i_req.value;
    end

    assign full      = (r_cnt == CW'(Q_DEPTH));
    assign o_job_vld = (r_cnt != '0);
    assign o_job     = r_mem[r_rp];
    assign w_wr      = push && !full;
    assign w_rd      = i_job_pop && o_job_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_job;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2a_back.sv
// Back end: peels digits off a job (divide by ten or shift by four per cycle),
// then emits characters most significant first into an output register.
// Depends on i2a_pkg.
`default_nettype none

module i2a_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_vld,
    output logic               o_job_pop,
    input  wire i2a_pkg::t_job i_job,
    output logic               empty,
    input  wire logic          pop,
    output i2a_pkg::t_res      o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam int CW = i2a_pkg::CNT_W;

    logic [1:0]    r_state, n_state;
    logic [31:0]   r_mag;
    logic          r_hex, r_upper, r_neg;
    logic [CW-1:0] r_nd, r_total;
    logic [3:0]    r_dig [i2a_pkg::MAX_CHARS];
    logic          r_out_vld, n_out_vld;
    i2a_pkg::t_res r_out;

    logic [63:0]   w_prod;
    logic [31:0]   w_quo, w_rem, w_mag_nx;
    logic [3:0]    w_digit, w_emit_d;
    logic          w_out_free, w_last, w_load;
    logic [7:0]    w_char, w_hex_off;
    i2a_pkg::t_res w_res;

    // divide by ten through the reciprocal; exact over 32 bits
    assign w_prod   = {32'd0, r_mag} * {32'd0, i2a_pkg::RECIP10};
    assign w_quo    = 32'(w_prod[63:i2a_pkg::RECIP_SHIFT]);
    assign w_rem    = r_mag - ((w_quo << 3) + (w_quo << 1));
    assign w_digit  = r_hex ? r_mag[3:0] : w_rem[3:0];
    assign w_mag_nx = r_hex ? {4'd0, r_mag[31:4]} : w_quo;

    assign w_out_free = !r_out_vld || pop;
    assign w_emit_d   = r_dig[r_nd - 1'b1];
    assign w_last     = !r_neg && (r_nd == CW'(1));
    assign w_hex_off  = r_upper ? i2a_pkg::UPPER_HEX_OFFSET : i2a_pkg::LOWER_HEX_OFFSET;

    always_comb begin
        if (r_neg) begin
            w_char = i2a_pkg::ASCII_MINUS;
        end else if (w_emit_d < 4'd10) begin
            w_char = i2a_pkg::ASCII_ZERO + {4'd0, w_emit_d};
        end else begin
            w_char = w_hex_off + {4'd0, w_emit_d};
        end
        w_res.character   = w_char;
        w_res.last_char   = w_last;
        w_res.total_chars = w_last ? r_total : '0;
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_vld;
    assign w_load    = (r_state == S_EMIT) && w_out_free;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld;
        if (pop && r_out_vld) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_mag_nx == 32'd0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mag   <= i_job.mag;
                r_hex   <= i_job.hex;
                r_upper <= i_job.upper;
                r_neg   <= i_job.neg;
                r_nd    <= '0;
            end
            S_CONV: begin
                r_dig[r_nd] <= w_digit;
                r_nd        <= r_nd + 1'b1;
                r_mag       <= w_mag_nx;
                r_total     <= r_nd + 1'b1 + CW'(r_neg);
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (r_neg) begin
                        r_neg <= 1'b0;
                    end else begin
                        r_nd <= r_nd - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign empty = !r_out_vld;
    assign o_res = r_out;

endmodule

`default_nettype wire

FILE: hdl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter, top level. The back end works on one job at a time:
// its digit loop takes one divide-by-ten or nibble per cycle over D digits
// (D = digit count, 1..10), then it emits C characters (D, or D+1 with a minus)
// at one character per cycle while the result side keeps popping, then takes a new job.
// Reset (synchronous, active low) empties the job queue and the result register.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int Q_DEPTH = i2a_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // request side
    input  wire logic          push,
    output logic               full,
    input  wire i2a_pkg::t_req i_req,
    // result side
    output logic               empty,
    input  wire logic          pop,
    output i2a_pkg::t_res      o_res
);

    // Front end classifies each request (decimal/hex, case, sign) and stores
    // the magnitude in a short job queue, so requests keep flowing in while
    // the back end is busy emitting an earlier value.
    logic          w_job_vld, w_job_pop;
    i2a_pkg::t_job w_job;

    i2a_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_req     (i_req),
        .o_job_vld (w_job_vld),
        .i_job_pop (w_job_pop),
        .o_job     (w_job)
    );

    // Back end: digits are produced least significant first into a small
    // buffer, then read back most significant first. A leading minus goes out
    // ahead of the digits; the final character carries the run length.
    // The output register lets the next character load as the current one pops.
    i2a_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (w_job_vld),
        .o_job_pop (w_job_pop),
        .i_job     (w_job),
        .empty     (empty),
        .pop       (pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for integer_to_ascii_formatter: random queue traffic on both sides,
// every character compared against an in-bench spelling of each request.
// Depends on i2a_pkg (request/result structs, format and ASCII constants) and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_TAIL    = 40;      // last requests go out with no new random idle bursts
    localparam int SETTLE_CYC   = 40;      // longer than the worst first-character latency
    localparam int CYCLE_LIMIT  = 400000;  // watchdog limit for a hung run
    localparam int PRINT_CAP    = 30;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    i2a_pkg::t_req i_req;
    logic empty;
    logic pop;
    i2a_pkg::t_res o_res;

    integer_to_ascii_formatter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    // requests still to be sent, and characters the block still owes us
    i2a_pkg::t_req req_backlog[$];
    i2a_pkg::t_res owed_chars[$];

    int   fault_count;
    int   cycle_count;
    int   reqs_sent;
    int   dec_reqs;
    int   hex_reqs;
    int   chars_checked;
    int   push_gap;
    int   pop_gap;
    logic calm_tail;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_fault(input string msg);
        if (fault_count < PRINT_CAP)
            $display("tb_top: cycle %0d: %s", cycle_count, msg);
        fault_count++;
    endtask

    // Spell one request into its expected characters, most significant first.
    // Decimal: two's complement, leading '-' on negatives, magnitude in 32-bit
    // unsigned math so the most negative value comes out as 2147483648.
    // Hex: any nonzero cmd, uppercase letters when the upper bit is set (cmd 3 too).
    // Only the final character carries last_char and the count; others carry 0.
    function automatic void spell_value(input i2a_pkg::t_req r);
        logic [31:0] mag;
        logic [7:0]  digs [0:10];
        logic [7:0]  alpha_off;
        logic [3:0]  nib;
        logic        neg;
        int          nd;
        int          total;
        int          i;
        i2a_pkg::t_res c;
        neg = 1'b0;
        nd  = 0;
        mag = r.value;
        if (r.cmd == i2a_pkg::CMD_DEC) begin
            if (mag[31]) begin
                neg = 1'b1;
                mag = 32'd0 - r.value;
            end
            while (nd == 0 || mag != 32'd0) begin
                digs[nd] = i2a_pkg::ASCII_ZERO + 8'(mag % 32'd10);
                mag = mag / 32'd10;
                nd++;
            end
        end else begin
            alpha_off = r.cmd[i2a_pkg::CMD_UPPER_BIT] ? i2a_pkg::UPPER_HEX_OFFSET
                                                      : i2a_pkg::LOWER_HEX_OFFSET;
            while (nd == 0 || mag != 32'd0) begin
                nib = mag[3:0];
                digs[nd] = (nib < 4'd10) ? i2a_pkg::ASCII_ZERO + 8'(nib)
                                         : alpha_off + 8'(nib);
                mag = mag >> 4;
                nd++;
            end
        end
        total = nd + (neg ? 1 : 0);
        if (neg) begin
            c.character   = i2a_pkg::ASCII_MINUS;
            c.last_char   = 1'b0;
            c.total_chars = '0;
            owed_chars.push_back(c);
        end
        for (i = nd - 1; i >= 0; i--) begin
            c.character   = digs[i];
            c.last_char   = (i == 0);
            c.total_chars = (i == 0) ? i2a_pkg::CNT_W'(total) : '0;
            owed_chars.push_back(c);
        end
    endfunction

    task automatic add_request(input logic [1:0] cmd, input logic [31:0] value);
        i2a_pkg::t_req r;
        r.cmd   = cmd;
        r.value = value;
        req_backlog.push_back(r);
    endtask

    // Driver: a request leaves on the edge where push is high and full is low.
    // The expectation is formed at that same edge, from the request still on the port.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                spell_value(i_req);
                reqs_sent++;
                if (i_req.cmd == i2a_pkg::CMD_DEC)
                    dec_reqs++;
                else
                    hex_reqs++;
            end
            if (req_backlog.size() < CALM_TAIL)
                calm_tail <= 1'b1;
            // a held request stays put until the block takes it
            if (!push || !full) begin
                if (push_gap > 0) begin
                    push_gap--;
                    push <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
                    push_gap = $urandom_range(0, 3);  // start a random idle burst
                    push <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    i_req <= req_backlog.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each popped character against the oldest owed one,
    // and stall the result side in random bursts.
    always @(posedge i_clk) begin
        i2a_pkg::t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (owed_chars.size() == 0) begin
                    note_fault($sformatf("unexpected character 0x%02h", o_res.character));
                end else begin
                    want = owed_chars.pop_front();
                    chars_checked++;
                    if (o_res.character !== want.character)
                        note_fault($sformatf("character 0x%02h, want 0x%02h",
                                             o_res.character, want.character));
                    if (o_res.last_char !== want.last_char)
                        note_fault($sformatf("last_char %b, want %b",
                                             o_res.last_char, want.last_char));
                    if (o_res.total_chars !== want.total_chars)
                        note_fault($sformatf("total_chars %0d, want %0d",
                                             o_res.total_chars, want.total_chars));
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                pop_gap = $urandom_range(0, 3);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: timeout, %0d characters still owed", owed_chars.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] pow;
        int          n;
        logic [1:0]  cmd;
        logic [31:0] value;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_req         = '0;
        fault_count   = 0;
        cycle_count   = 0;
        reqs_sent     = 0;
        dec_reqs      = 0;
        hex_reqs      = 0;
        chars_checked = 0;
        push_gap      = 0;
        pop_gap       = 0;
        calm_tail     = 1'b0;

        // directed: zero, extremes, digit-count steps, every format, unused selector
        add_request(i2a_pkg::CMD_DEC, 32'd0);
        add_request(i2a_pkg::CMD_DEC, 32'd1);
        add_request(i2a_pkg::CMD_DEC, 32'hFFFF_FFFF);           // -1
        add_request(i2a_pkg::CMD_DEC, 32'h7FFF_FFFF);           // largest positive
        add_request(i2a_pkg::CMD_DEC, 32'h8000_0000);           // most negative
        add_request(i2a_pkg::CMD_DEC, 32'h8000_0001);
        add_request(i2a_pkg::CMD_DEC, 32'd9);
        add_request(i2a_pkg::CMD_DEC, 32'd10);
        add_request(i2a_pkg::CMD_DEC, 32'd999_999_999);
        add_request(i2a_pkg::CMD_DEC, 32'd1_000_000_000);
        add_request(i2a_pkg::CMD_DEC, 32'd0 - 32'd1_000_000_000);
        add_request(i2a_pkg::CMD_HEX_LO, 32'd0);
        add_request(i2a_pkg::CMD_HEX_LO, 32'hFFFF_FFFF);
        add_request(i2a_pkg::CMD_HEX_LO, 32'hDEAD_BEEF);
        add_request(i2a_pkg::CMD_HEX_LO, 32'h0000_000A);
        add_request(i2a_pkg::CMD_HEX_LO, 32'h0000_0010);
        add_request(i2a_pkg::CMD_HEX_UP, 32'd0);
        add_request(i2a_pkg::CMD_HEX_UP, 32'hDEAD_BEEF);
        add_request(i2a_pkg::CMD_HEX_UP, 32'h0000_000F);
        add_request(i2a_pkg::CMD_HEX_UP, 32'h1234_5678);
        add_request(i2a_pkg::CMD_RSVD, 32'd0);
        add_request(i2a_pkg::CMD_RSVD, 32'hABCD_EF01);
        add_request(i2a_pkg::CMD_RSVD, 32'hFFFF_FFFF);

        // random: mix of full-range, small, and values at or just below powers of two or of ten
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            cmd = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: value = $urandom;
                1: value = $urandom_range(0, 40);
                2: value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
                3: begin
                    pow = 32'd1;
                    repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
                    value = pow - $urandom_range(0, 1);
                    if ($urandom_range(0, 1) == 1)
                        value = 32'd0 - value;
                end
                default: value = $urandom | 32'h8000_0000;
            endcase
            add_request(cmd, value);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (req_backlog.size() != 0 || push)
            @(posedge i_clk);
        while (owed_chars.size() != 0)
            @(posedge i_clk);
        // extra cycles catch any stray character after the last one owed
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("tb_top: %0d requests (%0d decimal, %0d hex), %0d characters compared",
                 reqs_sent, dec_reqs, hex_reqs, chars_checked);
        $display("tb_top: %0d mismatches", fault_count);
        if (fault_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/i2a_pkg.sv
hdl/i2a_front.sv
hdl/i2a_back.sv
hdl/integer_to_ascii_formatter.sv
sim/tb_top.sv
